// ----- src/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- src/itmm_pkg.sv -----
package itmm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int SUM_W    = 24;
	localparam int COUNT_W  = 8;
	localparam int MEAN_W   = 15;
	localparam int MAG_W    = 16;

	// samples beyond this count in one burst are dropped
	localparam logic [COUNT_W-1:0] MAX_SAMPLES = COUNT_W'(16);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;

	localparam int DIV_STEPS  = SUM_W;
	localparam int SQRT_STEPS = MAG_W;
	localparam int STEP_W     = 5;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

	// summary of one finished burst, handed from front to back
	typedef struct packed {
		logic signed [SUM_W-1:0]    real_sum;
		logic signed [SUM_W-1:0]    imag_sum;
		logic signed [SAMPLE_W-1:0] real_low;
		logic signed [SAMPLE_W-1:0] real_high;
		logic signed [SAMPLE_W-1:0] imag_low;
		logic signed [SAMPLE_W-1:0] imag_high;
		logic [COUNT_W-1:0]         count;
		logic                       overflow;
	} burst_t;

	typedef struct packed {
		logic   valid;
		burst_t burst;
	} burst_push_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} queue_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_SQUARE,
		ST_SUM,
		ST_ROOT,
		ST_OUT
	} back_state_t;

endpackage

// ----- src/itmm_ifs.sv -----
interface itmm_in_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [itmm_pkg::SAMPLE_W-1:0]   real_sample;
	logic signed [itmm_pkg::SAMPLE_W-1:0]   imag_sample;
	logic                                   last;

	modport source(output valid, real_sample, imag_sample, last, input ready);
	modport sink(input valid, real_sample, imag_sample, last, output ready);
endinterface

interface itmm_out_if;
	logic                           valid;
	logic                           ready;
	logic [itmm_pkg::MEAN_W-1:0]    real_mean;
	logic [itmm_pkg::MEAN_W-1:0]    imag_mean;
	logic [itmm_pkg::MAG_W-1:0]     magnitude;
	logic                           empty_burst;
	logic                           overflowed;

	modport source(output valid, real_mean, imag_mean, magnitude, empty_burst, overflowed,
		input ready);
	modport sink(input valid, real_mean, imag_mean, magnitude, empty_burst, overflowed,
		output ready);
endinterface

// ----- src/itmm_front.sv -----
module itmm_front (
	input  logic                    clk,
	input  logic                    arst_n,
	itmm_in_if.sink                 samples,
	input  itmm_pkg::queue_status_t qstat,
	output itmm_pkg::burst_push_t   push
);

	logic signed [itmm_pkg::SUM_W-1:0]    real_sum_q, imag_sum_q;
	logic signed [itmm_pkg::SAMPLE_W-1:0] real_low_q, real_high_q, imag_low_q, imag_high_q;
	logic [itmm_pkg::COUNT_W-1:0]         count_q;
	logic                                 ovf_q;

	logic   accept, take;
	itmm_pkg::burst_t nxt;

	assign samples.ready = !qstat.full;
	assign accept        = samples.valid && samples.ready;
	assign take          = count_q < itmm_pkg::MAX_SAMPLES;

	// state after folding in the current sample
	always_comb begin
		nxt.real_sum  = real_sum_q;
		nxt.imag_sum  = imag_sum_q;
		nxt.real_low  = real_low_q;
		nxt.real_high = real_high_q;
		nxt.imag_low  = imag_low_q;
		nxt.imag_high = imag_high_q;
		nxt.count     = count_q;
		nxt.overflow  = ovf_q;
		if (take) begin
			nxt.real_sum = real_sum_q + {{(itmm_pkg::SUM_W-itmm_pkg::SAMPLE_W)
				{samples.real_sample[itmm_pkg::SAMPLE_W-1]}}, samples.real_sample};
			nxt.imag_sum = imag_sum_q + {{(itmm_pkg::SUM_W-itmm_pkg::SAMPLE_W)
				{samples.imag_sample[itmm_pkg::SAMPLE_W-1]}}, samples.imag_sample};
			if (samples.real_sample < real_low_q)  nxt.real_low  = samples.real_sample;
			if (samples.real_sample > real_high_q) nxt.real_high = samples.real_sample;
			if (samples.imag_sample < imag_low_q)  nxt.imag_low  = samples.imag_sample;
			if (samples.imag_sample > imag_high_q) nxt.imag_high = samples.imag_sample;
			nxt.count = count_q + itmm_pkg::COUNT_W'(1);
		end else begin
			nxt.overflow = 1'b1;
		end
	end

	assign push.valid = accept && samples.last;
	assign push.burst = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			real_sum_q  <= '0;
			imag_sum_q  <= '0;
			real_low_q  <= itmm_pkg::SAMPLE_MAX;
			real_high_q <= itmm_pkg::SAMPLE_MIN;
			imag_low_q  <= itmm_pkg::SAMPLE_MAX;
			imag_high_q <= itmm_pkg::SAMPLE_MIN;
			count_q     <= '0;
			ovf_q       <= 1'b0;
		end else if (accept) begin
			if (samples.last) begin
				real_sum_q  <= '0;
				imag_sum_q  <= '0;
				real_low_q  <= itmm_pkg::SAMPLE_MAX;
				real_high_q <= itmm_pkg::SAMPLE_MIN;
				imag_low_q  <= itmm_pkg::SAMPLE_MAX;
				imag_high_q <= itmm_pkg::SAMPLE_MIN;
				count_q     <= '0;
				ovf_q       <= 1'b0;
			end else begin
				real_sum_q  <= nxt.real_sum;
				imag_sum_q  <= nxt.imag_sum;
				real_low_q  <= nxt.real_low;
				real_high_q <= nxt.real_high;
				imag_low_q  <= nxt.imag_low;
				imag_high_q <= nxt.imag_high;
				count_q     <= nxt.count;
				ovf_q       <= nxt.overflow;
			end
		end
	end

endmodule

// ----- src/itmm_queue.sv -----
module itmm_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  itmm_pkg::burst_push_t   push,
	input  logic                    pop,
	output itmm_pkg::burst_t        head,
	output itmm_pkg::queue_status_t qstat
);

	itmm_pkg::burst_t                entry_q [itmm_pkg::QUEUE_DEPTH];
	logic [itmm_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [itmm_pkg::QPTR_W:0]       fill_q;

	logic do_push, do_pop;

	assign qstat.full      = fill_q == (itmm_pkg::QPTR_W+1)'(itmm_pkg::QUEUE_DEPTH);
	assign qstat.not_empty = fill_q != '0;
	assign do_push         = push.valid && !qstat.full;
	assign do_pop          = pop && qstat.not_empty;
	assign head            = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.burst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + itmm_pkg::QPTR_W'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + itmm_pkg::QPTR_W'(1);
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + (itmm_pkg::QPTR_W+1)'(1);
				2'b01:   fill_q <= fill_q - (itmm_pkg::QPTR_W+1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ----- src/itmm_back.sv -----
module itmm_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  itmm_pkg::burst_t        head,
	input  itmm_pkg::queue_status_t qstat,
	output logic                    pop,
	itmm_out_if.source              results
);

	localparam int NUM_W = itmm_pkg::SUM_W + 1;
	localparam int SQ_W  = 2 * itmm_pkg::MEAN_W;
	localparam int RAD_W = 2 * itmm_pkg::MAG_W;
	localparam int REM_W = itmm_pkg::MAG_W + 2;

	itmm_pkg::back_state_t state_q, state_d;

	itmm_pkg::burst_t                  burst_q;
	logic [itmm_pkg::SUM_W-1:0]        re_quot_q, im_quot_q;
	logic [itmm_pkg::COUNT_W-1:0]      re_rem_q, im_rem_q, divisor_q;
	logic [itmm_pkg::STEP_W-1:0]       step_q;
	logic [itmm_pkg::MEAN_W-1:0]       re_mean_q, im_mean_q;
	logic [SQ_W-1:0]                   re_sq_q, im_sq_q;
	logic [RAD_W-1:0]                  rad_q;
	logic [REM_W-1:0]                  root_rem_q;
	logic [itmm_pkg::MAG_W-1:0]        root_q;

	logic signed [NUM_W-1:0]           re_num, im_num;
	logic [itmm_pkg::SUM_W-1:0]        re_abs, im_abs;
	logic [itmm_pkg::COUNT_W-1:0]      divisor;
	logic [itmm_pkg::COUNT_W:0]        re_sh, im_sh;
	logic                              re_bit, im_bit;
	logic [REM_W+1:0]                  rt_sh, rt_trial;
	logic                              rt_bit;
	logic                              last_step;

	// numerator and divisor for the trimmed mean; bursts of two samples or fewer are not trimmed
	always_comb begin
		if (burst_q.count > itmm_pkg::COUNT_W'(2)) begin
			re_num = {burst_q.real_sum[itmm_pkg::SUM_W-1], burst_q.real_sum}
				- NUM_W'(burst_q.real_low) - NUM_W'(burst_q.real_high);
			im_num = {burst_q.imag_sum[itmm_pkg::SUM_W-1], burst_q.imag_sum}
				- NUM_W'(burst_q.imag_low) - NUM_W'(burst_q.imag_high);
			divisor = burst_q.count - itmm_pkg::COUNT_W'(2);
		end else begin
			re_num  = {burst_q.real_sum[itmm_pkg::SUM_W-1], burst_q.real_sum};
			im_num  = {burst_q.imag_sum[itmm_pkg::SUM_W-1], burst_q.imag_sum};
			divisor = (burst_q.count == itmm_pkg::COUNT_W'(2)) ? itmm_pkg::COUNT_W'(2)
				: itmm_pkg::COUNT_W'(1);
		end
		// floor of the magnitude equals magnitude of the truncated quotient
		re_abs = re_num[NUM_W-1] ? itmm_pkg::SUM_W'(-re_num) : re_num[itmm_pkg::SUM_W-1:0];
		im_abs = im_num[NUM_W-1] ? itmm_pkg::SUM_W'(-im_num) : im_num[itmm_pkg::SUM_W-1:0];
	end

	// one restoring division step per cycle on each component
	always_comb begin
		re_sh  = {re_rem_q, re_quot_q[itmm_pkg::SUM_W-1]};
		im_sh  = {im_rem_q, im_quot_q[itmm_pkg::SUM_W-1]};
		re_bit = re_sh >= {1'b0, divisor_q};
		im_bit = im_sh >= {1'b0, divisor_q};
	end

	// one digit-by-digit square root step per cycle
	always_comb begin
		rt_sh    = {root_rem_q, rad_q[RAD_W-1 -: 2]};
		rt_trial = (REM_W+2)'({root_q, 2'b01});
		rt_bit   = rt_sh >= rt_trial;
	end

	always_comb begin
		case (state_q)
			itmm_pkg::ST_DIV:  last_step = step_q == itmm_pkg::STEP_W'(itmm_pkg::DIV_STEPS - 1);
			itmm_pkg::ST_ROOT: last_step = step_q == itmm_pkg::STEP_W'(itmm_pkg::SQRT_STEPS);
			default:           last_step = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itmm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		pop           = 1'b0;
		results.valid = 1'b0;
		case (state_q)
			itmm_pkg::ST_IDLE: begin
				if (qstat.not_empty) begin
					pop     = 1'b1;
					state_d = itmm_pkg::ST_PREP;
				end
			end
			itmm_pkg::ST_PREP:   state_d = itmm_pkg::ST_DIV;
			itmm_pkg::ST_DIV:    if (last_step) state_d = itmm_pkg::ST_SQUARE;
			itmm_pkg::ST_SQUARE: state_d = itmm_pkg::ST_SUM;
			itmm_pkg::ST_SUM:    state_d = itmm_pkg::ST_ROOT;
			itmm_pkg::ST_ROOT:   if (last_step) state_d = itmm_pkg::ST_OUT;
			itmm_pkg::ST_OUT: begin
				results.valid = 1'b1;
				if (results.ready) state_d = itmm_pkg::ST_IDLE;
			end
			default: state_d = itmm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			itmm_pkg::ST_IDLE: begin
				if (qstat.not_empty) burst_q <= head;
			end
			itmm_pkg::ST_PREP: begin
				re_quot_q <= re_abs;
				im_quot_q <= im_abs;
				re_rem_q  <= '0;
				im_rem_q  <= '0;
				divisor_q <= divisor;
				step_q    <= '0;
			end
			itmm_pkg::ST_DIV: begin
				re_rem_q  <= re_bit ? itmm_pkg::COUNT_W'(re_sh - {1'b0, divisor_q})
					: re_sh[itmm_pkg::COUNT_W-1:0];
				im_rem_q  <= im_bit ? itmm_pkg::COUNT_W'(im_sh - {1'b0, divisor_q})
					: im_sh[itmm_pkg::COUNT_W-1:0];
				re_quot_q <= {re_quot_q[itmm_pkg::SUM_W-2:0], re_bit};
				im_quot_q <= {im_quot_q[itmm_pkg::SUM_W-2:0], im_bit};
				step_q    <= step_q + itmm_pkg::STEP_W'(1);
			end
			itmm_pkg::ST_SQUARE: begin
				// saturate at the largest positive 16-bit value
				re_mean_q <= (|re_quot_q[itmm_pkg::SUM_W-1:itmm_pkg::MEAN_W]) ? '1
					: re_quot_q[itmm_pkg::MEAN_W-1:0];
				im_mean_q <= (|im_quot_q[itmm_pkg::SUM_W-1:itmm_pkg::MEAN_W]) ? '1
					: im_quot_q[itmm_pkg::MEAN_W-1:0];
			end
			itmm_pkg::ST_SUM: begin
				re_sq_q <= SQ_W'(re_mean_q) * SQ_W'(re_mean_q);
				im_sq_q <= SQ_W'(im_mean_q) * SQ_W'(im_mean_q);
				step_q  <= '0;
			end
			itmm_pkg::ST_ROOT: begin
				if (step_q == '0) begin
					// first step: load the radicand, digit pairs follow
					rad_q      <= RAD_W'(re_sq_q) + RAD_W'(im_sq_q);
					root_rem_q <= '0;
					root_q     <= '0;
				end else begin
					rad_q      <= {rad_q[RAD_W-3:0], 2'b00};
					root_rem_q <= rt_bit ? REM_W'(rt_sh - rt_trial) : rt_sh[REM_W-1:0];
					root_q     <= {root_q[itmm_pkg::MAG_W-2:0], rt_bit};
				end
				step_q <= step_q + itmm_pkg::STEP_W'(1);
			end
			default: ;
		endcase
	end

	assign results.real_mean   = re_mean_q;
	assign results.imag_mean   = im_mean_q;
	assign results.magnitude   = root_q;
	assign results.empty_burst = burst_q.count == '0;
	assign results.overflowed  = burst_q.overflow;

endmodule

// ----- src/iq_trimmed_mean_magnitude.sv -----
// Trimmed-mean magnitude of a burst of complex samples. Sample pairs arrive on
// the samples channel, the final pair marked by last; each burst gives one
// transaction on the results channel carrying the absolute trimmed mean of the
// real and imaginary parts (sum less largest and smallest, divided by count
// minus two, or the plain mean for bursts of two samples or fewer, truncated
// toward zero, saturated at 32767), the floor square root of the sum of their
// squares, and flags for an empty burst and for samples past MAX_SAMPLES that
// were dropped. The front takes one sample per cycle, keeping running sums and
// min/max per component, and hands each finished burst to a two-entry queue.
// The back drains that queue one burst at a time: it loads a burst, sets up a
// serial divider that works on both components together, runs it, saturates
// the means, squares them, loads the radicand and runs 16 steps of a
// digit-by-digit square root before the result is offered; the result then
// sits in the output register until taken, and only then does the back take
// the next burst. Samples keep flowing while the back works, and the front only
// stalls once two finished bursts are waiting in the queue.
module iq_trimmed_mean_magnitude (
	input  logic        clk,
	input  logic        arst_n,
	itmm_in_if.sink     samples,
	itmm_out_if.source  results
);

	// burst summaries from the accumulator into the queue
	itmm_pkg::burst_push_t   push;
	// head of the queue and its fill state
	itmm_pkg::burst_t        head;
	itmm_pkg::queue_status_t qstat;
	// back end takes the head of the queue
	logic                    pop;

	// accumulator: sums, min/max and sample count per burst
	itmm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples),
		.qstat  (qstat),
		.push   (push)
	);

	// decouples the accumulator from the slow divide and root
	itmm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	// trimmed mean, saturation, squares and square root
	itmm_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.results(results)
	);

endmodule

// ----- src/itmm_checker.sv -----
`include "assert_macros.svh"

module itmm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [itmm_pkg::MEAN_W-1:0]  real_mean,
	input logic [itmm_pkg::MEAN_W-1:0]  imag_mean,
	input logic [itmm_pkg::MAG_W-1:0]   magnitude,
	input logic                         empty_burst
);

	logic [itmm_pkg::MAG_W-1:0] mean_sum;
	logic                       all_zero;
	logic                       mag_covers;

	assign mean_sum   = itmm_pkg::MAG_W'(real_mean) + itmm_pkg::MAG_W'(imag_mean);
	assign all_zero   = mean_sum == '0 && magnitude == '0;
	assign mag_covers = magnitude >= itmm_pkg::MAG_W'(real_mean)
		&& magnitude >= itmm_pkg::MAG_W'(imag_mean);

	// a result stays offered until taken
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// an empty burst reports all zeros
	`ASSERT_SAME(a_empty_zero, clk, arst_n, out_valid && empty_burst, all_zero)

	// the magnitude is never below either component
	`ASSERT_SAME(a_mag_low, clk, arst_n, out_valid, mag_covers)

	// nor above their sum
	`ASSERT_SAME(a_mag_high, clk, arst_n, out_valid, magnitude <= mean_sum)

endmodule

bind iq_trimmed_mean_magnitude itmm_checker u_itmm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.real_mean  (results.real_mean),
	.imag_mean  (results.imag_mean),
	.magnitude  (results.magnitude),
	.empty_burst(results.empty_burst)
);
